// ===== rtl/clcc_pkg.sv =====
// Shared types, codes and helpers for the command line checksum checker.
// Used by clcc_step and command_line_checksum_checker. No dependencies.
`default_nettype none

package clcc_pkg;

  localparam logic [7:0] START_CHAR_RESET = 8'h24;  // '$'
  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] CHAR_STAR        = 8'h2A;
  localparam logic [7:0] CHAR_CARET       = 8'h5E;

  typedef enum logic [1:0] {
    PH_LETTER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HEX    = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_ADD  = 2'd1,
    CK_XOR  = 2'd2,
    CK_FAIL = 2'd3
  } check_kind_t;

  typedef enum logic [2:0] {
    ROLE_TOKEN  = 3'd0,
    ROLE_SEP    = 3'd1,
    ROLE_MARKER = 3'd2,
    ROLE_HEX    = 3'd3,
    ROLE_IGNORE = 3'd4
  } byte_role_t;

  typedef struct packed {
    logic [7:0]  sum_add;
    logic [7:0]  sum_xor;
    phase_t      phase;
    check_kind_t check_kind;
    logic [3:0]  tokens_seen;
    logic [7:0]  hex_value;
    logic [1:0]  hex_digits;
  } line_state_t;

  typedef struct packed {
    logic [3:0] token_number;
    byte_role_t byte_role;
    logic       line_done;
    logic       line_ok;
    logic [3:0] token_count;
  } result_t;

  localparam line_state_t LINE_STATE_CLEAR = '{
    sum_add:     8'd0,
    sum_xor:     8'd0,
    phase:       PH_LETTER,
    check_kind:  CK_NONE,
    tokens_seen: 4'd1,
    hex_value:   8'd0,
    hex_digits:  2'd0
  };

  // {is_digit, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/command_line_checksum_checker.sv =====
// Command line checksum checker: checks the trailing hex checksum of command lines.
// Top level; depends on clcc_pkg and clcc_step.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) carries the characters
//   of one line after its start character, command letter first; last_byte marks
//   the final character. Output channel (out_valid/out_ready) returns one result
//   per character: token_number, byte_role, and on the last character line_done,
//   line_ok and token_count (0 when the line fails).
//   cfg_write/cfg_data load start_char, which seeds both sums; write it only
//   while no transaction is in flight.
// Timing:
//   Two register stages (input register, result register); each result passes
//   through both. One character per cycle sustained while out_ready is high;
//   the per-byte state update is an 8-bit add/xor followed by a compare.
// Reset:
//   rst (synchronous) empties both stages, clears the line state so the next
//   byte is a command letter, and sets start_char to '$'.
// Stall:
//   When out_ready is low the result holds; the input register still takes one
//   more transaction, then in_ready drops until the result is taken.
`default_nettype none

module command_line_checksum_checker #(
  parameter int unsigned MAX_TOKENS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] token_number,
  output logic [2:0] byte_role,
  output logic       line_done,
  output logic       line_ok,
  output logic [3:0] token_count
);
  import clcc_pkg::*;

  logic [7:0]  start_char;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  line_state_t line_st;
  line_state_t line_st_next;
  result_t     step_res;
  result_t     res;
  logic        out_free;
  logic        advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RESET;
    end else if (cfg_write) begin
      start_char <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  clcc_step #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_step (
    .st        (line_st),
    .start_char(start_char),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .st_next   (line_st_next),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_st <= LINE_STATE_CLEAR;
    end else if (advance) begin
      line_st <= line_st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign token_number = res.token_number;
  assign byte_role    = res.byte_role;
  assign line_done    = res.line_done;
  assign line_ok      = res.line_ok;
  assign token_count  = res.token_count;

  a_fail_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_ok |-> token_count == 4'd0)
    else $error("failed line reports a nonzero token count");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_done |-> !line_ok)
    else $error("line_ok set on a result that does not end a line");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> token_count <= 4'(MAX_TOKENS))
    else $error("token count beyond the token limit");

  a_letter_clean: assert property (@(posedge clk) disable iff (rst)
    line_st.phase == PH_LETTER |->
      line_st.tokens_seen == 4'd1 && line_st.check_kind == CK_NONE)
    else $error("line state not cleared at start of line");

endmodule

`default_nettype wire

// ===== rtl/clcc_step.sv =====
// Per-byte parse step: next line state and result for one character.
// Depends on clcc_pkg.
`default_nettype none

module clcc_step #(
  parameter int unsigned MAX_TOKENS = 10
) (
  input  clcc_pkg::line_state_t st,
  input  logic [7:0]            start_char,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output clcc_pkg::line_state_t st_next,
  output clcc_pkg::result_t     res
);
  import clcc_pkg::*;

  localparam logic [3:0] MaxTok = 4'(MAX_TOKENS);

  line_state_t s;
  logic [4:0]  nib;
  logic        ok;

  always_comb begin
    s   = st;
    nib = hex_nibble(data_byte);
    ok  = 1'b0;
    res.token_number = (st.tokens_seen != 4'd0) ? st.tokens_seen - 4'd1 : 4'd0;
    res.byte_role    = ROLE_IGNORE;
    res.line_done    = last_byte;
    res.line_ok      = 1'b0;
    res.token_count  = 4'd0;

    unique case (st.phase)
      PH_LETTER: begin
        s.sum_add        = start_char + data_byte;
        s.sum_xor        = start_char ^ data_byte;
        s.tokens_seen    = 4'd1;
        s.phase          = PH_BODY;
        res.token_number = 4'd0;
        res.byte_role    = ROLE_TOKEN;
      end
      PH_BODY: begin
        priority if (data_byte == CHAR_SPACE) begin
          res.token_number = st.tokens_seen;
          res.byte_role    = ROLE_SEP;
          if (st.tokens_seen >= MaxTok) begin
            s.check_kind = CK_FAIL;
            s.phase      = PH_IGNORE;
          end else begin
            s.sum_add     = st.sum_add + data_byte;
            s.sum_xor     = st.sum_xor ^ data_byte;
            s.tokens_seen = st.tokens_seen + 4'd1;
          end
        end else if (data_byte == CHAR_STAR || data_byte == CHAR_CARET) begin
          s.check_kind  = (data_byte == CHAR_STAR) ? CK_ADD : CK_XOR;
          s.hex_value   = 8'd0;
          s.hex_digits  = 2'd0;
          s.phase       = PH_HEX;
          res.byte_role = ROLE_MARKER;
        end else begin
          s.sum_add     = st.sum_add + data_byte;
          s.sum_xor     = st.sum_xor ^ data_byte;
          res.byte_role = ROLE_TOKEN;
        end
      end
      PH_HEX: begin
        if (nib[4] && st.hex_digits < 2'd2) begin
          s.hex_value   = {st.hex_value[3:0], nib[3:0]};
          s.hex_digits  = st.hex_digits + 2'd1;
          res.byte_role = ROLE_HEX;
        end else begin
          s.phase = PH_IGNORE;
        end
      end
      PH_IGNORE: begin
        res.byte_role = ROLE_IGNORE;
      end
      default: begin
        res.byte_role = ROLE_IGNORE;
      end
    endcase

    // checksum compare uses the state after this byte
    unique case (s.check_kind)
      CK_NONE: ok = 1'b1;
      CK_ADD:  ok = (s.hex_value == s.sum_add);
      CK_XOR:  ok = (s.hex_value == s.sum_xor);
      default: ok = 1'b0;
    endcase

    if (last_byte) begin
      res.line_ok     = ok;
      res.token_count = ok ? s.tokens_seen : 4'd0;
      s               = LINE_STATE_CLEAR;
    end
    st_next = s;
  end

endmodule

`default_nettype wire
